### rtl/srsw_pkg.sv
// Shared types and constants for the selective-repeat sender window.
// Holds the item structs, opcodes, register indexes and control state codes.
// No dependencies.
package srsw_pkg;

    // Default sizing, handed to the top level's parameters
    localparam int WINDOW_MAX_DEF    = 8;
    localparam int STAMP_BITS_DEF    = 16;

    // Fixed packet geometry
    localparam int PACKET_BYTES      = 1024;
    localparam int PACKETS_PER_CHUNK = 8;
    localparam int CHUNK_MAX         = PACKETS_PER_CHUNK * PACKET_BYTES;

    // Configuration port
    localparam int CFG_DATA_W        = 15;
    localparam int WIN_SIZE_RST      = 4;
    localparam int TIMEOUT_RST       = 3;

    typedef enum logic {
        CFG_WINDOW_SIZE   = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_ACK   = 2'd1,
        OP_TICK  = 2'd2,
        OP_POLL  = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  ack_seq;
        logic [13:0] chunk_bytes;
        logic        final_chunk;
    } t_in_item;

    typedef struct packed {
        logic        send_valid;
        logic [2:0]  packet_seq;
        logic [12:0] byte_offset;
        logic [10:0] byte_count;
        logic        final_packet;
        logic [3:0]  window_base;
        logic        chunk_done;
        logic        last_result;
    } t_out_item;

endpackage

### rtl/selective_repeat_sender_window_top.sv
// Selective-repeat sender window, top level: config registers, control, stamp memory.
// Start, ack and tick give their one result on the cycle after the transfer; busy stays low.
// A poll keeps busy high through its scan (win: effective window): one stamp read per
// slot, then a step to judge the last read and one to release the held request.
// At most one result per cycle on o_valid; the receiver cannot stall. Synchronous reset,
// no clearing pass. Depends on srsw_pkg, srsw_ctrl and srsw_stamp_ram.
module selective_repeat_sender_window_top #(
    parameter int WINDOW_MAX = srsw_pkg::WINDOW_MAX_DEF,
    parameter int STAMP_BITS = srsw_pkg::STAMP_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  srsw_pkg::t_in_item              i_item,
    output logic                            o_valid,
    output srsw_pkg::t_out_item             o_result,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [srsw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import srsw_pkg::*;

    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int WSW   = (CNT_W > 4) ? CNT_W : 4;

    logic [3:0]            r_window_size;
    logic [CFG_DATA_W-1:0] r_timeout;
    logic [WSW-1:0]        ws_ext;
    logic [CNT_W-1:0]      win_eff;
    logic                  accept;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [STAMP_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [STAMP_BITS-1:0] ram_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= 4'(WIN_SIZE_RST);
            r_timeout     <= CFG_DATA_W'(TIMEOUT_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_SIZE:   r_window_size <= i_cfg_data[3:0];
                CFG_TIMEOUT_TICKS: r_timeout     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Effective window: zero acts as one, oversize clamps to the slot count
    always_comb begin
        ws_ext = WSW'(r_window_size);
        if (ws_ext == '0) begin
            win_eff = CNT_W'(1);
        end else if (ws_ext > WSW'(WINDOW_MAX)) begin
            win_eff = CNT_W'(WINDOW_MAX);
        end else begin
            win_eff = CNT_W'(ws_ext);
        end
    end

    assign accept = start && !busy;

    srsw_ctrl #(
        .WINDOW_MAX (WINDOW_MAX),
        .STAMP_BITS (STAMP_BITS),
        .AW         (AW),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_win       (win_eff),
        .i_timeout   (r_timeout),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    srsw_stamp_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (STAMP_BITS),
        .AW    (AW)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

### rtl/srsw_stamp_ram.sv
// Send time stamp memory: one write port, one read port, registered read data.
// Entries hold no reset value; a stamp is only used once its slot was sent.
// Uses no package items.
module srsw_stamp_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16,
    parameter int AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/srsw_ctrl.sv
// Window control: slot flags, base, tick counter, poll scan and result register.
// Drives the stamp memory, which is addressed as a ring behind a head pointer.
// Depends on srsw_pkg.
module srsw_ctrl #(
    parameter int WINDOW_MAX = srsw_pkg::WINDOW_MAX_DEF,
    parameter int STAMP_BITS = srsw_pkg::STAMP_BITS_DEF,
    parameter int AW         = 3,
    parameter int CNT_W      = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  srsw_pkg::t_in_item            i_item,
    input  logic [CNT_W-1:0]              i_win,
    input  logic [srsw_pkg::CFG_DATA_W-1:0] i_timeout,
    output logic                          o_busy,
    output logic                          o_valid,
    output srsw_pkg::t_out_item           o_result,
    output logic                          o_ram_we,
    output logic [AW-1:0]                 o_ram_waddr,
    output logic [STAMP_BITS-1:0]         o_ram_wdata,
    output logic                          o_ram_re,
    output logic [AW-1:0]                 o_ram_raddr,
    input  logic [STAMP_BITS-1:0]         i_ram_rdata
);
    import srsw_pkg::*;

    localparam int HW    = AW + 2;
    localparam int SEQ_W = CNT_W + 5;
    localparam int TW    = (STAMP_BITS > CFG_DATA_W) ? STAMP_BITS : CFG_DATA_W;
    localparam int OFF_W = 13;
    localparam int LEN_W = 14;

    // Control state
    t_state                r_state, n_state;
    logic [WINDOW_MAX-1:0] r_acked, n_acked;
    logic [WINDOW_MAX-1:0] r_sent,  n_sent;
    logic [3:0]            r_base,  n_base;
    logic [STAMP_BITS-1:0] r_tick,  n_tick;
    logic [3:0]            r_total, n_total;
    logic [LEN_W-1:0]      r_len,   n_len;
    logic                  r_final, n_final;
    logic [AW-1:0]         r_head,  n_head;
    logic [CNT_W-1:0]      r_idx,   n_idx;
    logic [CNT_W-1:0]      r_win,   n_win;
    logic                  r_ev_act, n_ev_act;
    logic [AW-1:0]         r_ev_idx, n_ev_idx;
    logic [AW-1:0]         r_ev_addr, n_ev_addr;
    logic                  r_pend_v, n_pend_v;
    t_out_item             r_pend,  n_pend;
    logic                  r_out_v, n_out_v;
    t_out_item             r_out,   n_out;

    // Slide amount and evaluation terms
    logic [CNT_W-1:0]      lead;
    logic                  run;
    t_opcode               op;
    logic [LEN_W-1:0]      len_sat;
    logic [SEQ_W-1:0]      ack_ext;
    logic [AW-1:0]         ack_slot;
    logic [SEQ_W-1:0]      ev_seq;
    logic [STAMP_BITS-1:0] age;
    logic                  ev_go;
    logic [OFF_W-1:0]      ev_off;
    logic [LEN_W-1:0]      ev_diff;
    logic [LEN_W-1:0]      ev_cnt;
    t_out_item             ev_res;

    // Ring address of a logical slot
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [CNT_W-1:0] b);
        logic [HW-1:0] sum;
        sum = HW'(a) + HW'(b);
        if (sum >= HW'(WINDOW_MAX)) begin
            sum = sum - HW'(WINDOW_MAX);
        end
        return sum[AW-1:0];
    endfunction

    // Count of leading acknowledged slots inside the window
    always_comb begin
        lead = '0;
        run  = 1'b1;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (run && r_acked[i] && (CNT_W'(i) < i_win)) begin
                lead = lead + 1'b1;
            end else begin
                run = 1'b0;
            end
        end
    end

    // Start and ack decode
    assign op       = t_opcode'(i_item.opcode);
    assign len_sat  = (i_item.chunk_bytes > LEN_W'(CHUNK_MAX)) ? LEN_W'(CHUNK_MAX)
                                                               : i_item.chunk_bytes;
    assign ack_ext  = SEQ_W'(i_item.ack_seq);
    assign ack_slot = AW'(ack_ext - SEQ_W'(r_base));

    // Evaluation of the slot whose stamp has just been read
    always_comb begin
        ev_seq  = SEQ_W'(r_base) + SEQ_W'(r_ev_idx);
        age     = r_tick - i_ram_rdata;
        ev_go   = (ev_seq < SEQ_W'(r_total)) &&
                  (!r_sent[r_ev_idx] ||
                   (!r_acked[r_ev_idx] && (TW'(age) > TW'(i_timeout))));
        ev_off  = OFF_W'(ev_seq[2:0]) * OFF_W'(PACKET_BYTES);
        ev_diff = (LEN_W'(ev_off) < r_len) ? (r_len - LEN_W'(ev_off)) : '0;
        ev_cnt  = (ev_diff > LEN_W'(PACKET_BYTES)) ? LEN_W'(PACKET_BYTES) : ev_diff;
        ev_res              = '0;
        ev_res.send_valid   = 1'b1;
        ev_res.packet_seq   = ev_seq[2:0];
        ev_res.byte_offset  = ev_off;
        ev_res.byte_count   = 11'(ev_cnt);
        ev_res.final_packet = r_final && ((ev_seq + 1'b1) == SEQ_W'(r_total));
    end

    // Next state and outputs
    always_comb begin
        n_state   = r_state;
        n_acked   = r_acked;
        n_sent    = r_sent;
        n_base    = r_base;
        n_tick    = r_tick;
        n_total   = r_total;
        n_len     = r_len;
        n_final   = r_final;
        n_head    = r_head;
        n_idx     = r_idx;
        n_win     = r_win;
        n_ev_act  = 1'b0;
        n_ev_idx  = r_ev_idx;
        n_ev_addr = r_ev_addr;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_out_v   = 1'b0;
        n_out     = r_out;

        o_ram_we    = 1'b0;
        o_ram_waddr = r_ev_addr;
        o_ram_wdata = r_tick;
        o_ram_re    = 1'b0;
        o_ram_raddr = wrap_add(r_head, r_idx);

        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_out_v = 1'b1;
                    n_out   = '0;
                    n_out.last_result = 1'b1;
                    case (op)
                        OP_START: begin
                            n_len   = len_sat;
                            n_total = 4'((32'(len_sat) + 32'(PACKET_BYTES - 1))
                                         / PACKET_BYTES);
                            n_final = i_item.final_chunk;
                            n_acked = '0;
                            n_sent  = '0;
                            n_base  = '0;
                        end
                        OP_ACK: begin
                            if ((ack_ext >= SEQ_W'(r_base)) &&
                                (ack_ext < (SEQ_W'(r_base) + SEQ_W'(i_win)))) begin
                                n_acked[ack_slot] = 1'b1;
                            end
                        end
                        OP_TICK: begin
                            n_tick = r_tick + 1'b1;
                        end
                        OP_POLL: begin
                            // slide past acknowledged leading slots, then scan
                            n_out_v  = 1'b0;
                            n_acked  = r_acked >> lead;
                            n_sent   = r_sent >> lead;
                            n_base   = 4'(SEQ_W'(r_base) + SEQ_W'(lead));
                            n_head   = wrap_add(r_head, lead);
                            n_win    = i_win;
                            n_idx    = '0;
                            n_pend_v = 1'b0;
                            n_state  = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // evaluate the slot read last cycle; hold one send back so
                // the final one can carry the last flag
                if (r_ev_act && ev_go) begin
                    n_sent[r_ev_idx] = 1'b1;
                    o_ram_we = 1'b1;
                    if (r_pend_v) begin
                        n_out_v = 1'b1;
                        n_out   = r_pend;
                    end
                    n_pend_v = 1'b1;
                    n_pend   = ev_res;
                end

                // issue the next stamp read
                if (r_idx < r_win) begin
                    o_ram_re  = 1'b1;
                    n_ev_act  = 1'b1;
                    n_ev_idx  = r_idx[AW-1:0];
                    n_ev_addr = wrap_add(r_head, r_idx);
                    n_idx     = r_idx + 1'b1;
                end else if (!r_ev_act) begin
                    n_out_v  = 1'b1;
                    n_out    = r_pend_v ? r_pend : t_out_item'('0);
                    n_out.last_result = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // window status after this step
        n_out.window_base = n_base;
        n_out.chunk_done  = (n_base >= n_total);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_acked  <= '0;
            r_sent   <= '0;
            r_base   <= '0;
            r_tick   <= '0;
            r_total  <= '0;
            r_len    <= '0;
            r_final  <= 1'b0;
            r_head   <= '0;
            r_idx    <= '0;
            r_win    <= '0;
            r_ev_act <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acked  <= n_acked;
            r_sent   <= n_sent;
            r_base   <= n_base;
            r_tick   <= n_tick;
            r_total  <= n_total;
            r_len    <= n_len;
            r_final  <= n_final;
            r_head   <= n_head;
            r_idx    <= n_idx;
            r_win    <= n_win;
            r_ev_act <= n_ev_act;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ev_idx  <= n_ev_idx;
        r_ev_addr <= n_ev_addr;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the selective-repeat sender window: a directed table,
// a timeout run and random phases, checked against an in-bench window model or typed results.
// Depends on srsw_pkg and selective_repeat_sender_window_top.
module tb_top;
    import srsw_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RST_CYCLES  = 4;
    localparam int SETTLE      = 16;      // a poll holds busy high while it scans the window
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 25;
    localparam int SLOTS       = WINDOW_MAX_DEF;

    typedef struct {
        bit                    is_cfg;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_in_item              item;
        bit                    typed;
        t_out_item             result;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_item              i_item;
    logic                  o_valid;
    t_out_item             o_result;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Window model state
    logic [3:0]            win_size_r;
    logic [14:0]           timeout_r;
    bit                    acked [SLOTS];
    bit                    sent  [SLOTS];
    logic [15:0]           stamp [SLOTS];
    int unsigned           base;
    int unsigned           total_pkts;
    int unsigned           chunk_len;
    bit                    file_end;
    logic [15:0]           now_tick;

    t_out_item             due_results[$];
    int unsigned           err_count   = 0;
    int unsigned           cycle_count = 0;
    bit                    no_idle     = 1'b0;

    selective_repeat_sender_window_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, due_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned effective_window();
        if (win_size_r == 4'd0) return 1;
        if (win_size_r > SLOTS) return SLOTS;
        return win_size_r;
    endfunction

    function automatic t_out_item make_result(bit valid, int unsigned seq, int unsigned off,
                                              int unsigned cnt, bit fin, bit last);
        t_out_item r;
        r.send_valid   = valid;
        r.packet_seq   = 3'(seq);
        r.byte_offset  = 13'(off);
        r.byte_count   = 11'(cnt);
        r.final_packet = fin;
        r.window_base  = 4'(base);
        r.chunk_done   = (base >= total_pkts);
        r.last_result  = last;
        return r;
    endfunction

    // Advance the window model by one item and queue the results it causes
    function automatic void window_step(t_in_item it);
        int unsigned win;
        int unsigned shift;
        int unsigned len;
        int unsigned seq;
        int unsigned off;
        int unsigned cnt;
        int unsigned sent_n;
        bit          go;
        logic [15:0] age;
        win    = effective_window();
        sent_n = 0;
        case (t_opcode'(it.opcode))
            OP_START: begin
                len = it.chunk_bytes;
                if (len > CHUNK_MAX) len = CHUNK_MAX;
                chunk_len  = len;
                total_pkts = (len + PACKET_BYTES - 1) / PACKET_BYTES;
                file_end   = it.final_chunk;
                for (int i = 0; i < SLOTS; i++) begin
                    acked[i] = 1'b0;
                    sent[i]  = 1'b0;
                end
                base = 0;
            end
            OP_ACK: begin
                if (it.ack_seq >= base && it.ack_seq < base + win)
                    acked[it.ack_seq - base] = 1'b1;
            end
            OP_TICK: begin
                now_tick = now_tick + 16'd1;
            end
            OP_POLL: begin
                // slide past leading acknowledged slots, clearing the vacated top
                shift = 0;
                while (shift < win && acked[shift]) shift++;
                if (shift != 0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (i + shift < SLOTS) begin
                            acked[i] = acked[i + shift];
                            sent[i]  = sent[i + shift];
                            stamp[i] = stamp[i + shift];
                        end else begin
                            acked[i] = 1'b0;
                            sent[i]  = 1'b0;
                        end
                    end
                    base += shift;
                end
                // fresh slots, and unacknowledged ones past their timeout
                for (int i = 0; i < win; i++) begin
                    seq = base + i;
                    if (seq < total_pkts) begin
                        go = !sent[i];
                        if (!go && !acked[i]) begin
                            age = now_tick - stamp[i];
                            go  = (age > timeout_r);
                        end
                        if (go) begin
                            off = seq * PACKET_BYTES;
                            cnt = (off < chunk_len) ? chunk_len - off : 0;
                            if (cnt > PACKET_BYTES) cnt = PACKET_BYTES;
                            sent[i]  = 1'b1;
                            stamp[i] = now_tick;
                            due_results.push_back(make_result(1'b1, seq, off, cnt,
                                file_end && (seq + 1 == total_pkts), 1'b0));
                            sent_n++;
                        end
                    end
                end
                if (sent_n != 0)
                    due_results[due_results.size() - 1].last_result = 1'b1;
            end
            default: begin
            end
        endcase
        if (sent_n == 0)
            due_results.push_back(make_result(1'b0, 0, 0, 0, 1'b0, 1'b1));
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Result checker: every strobed transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (due_results.size() == 0) begin
                $error("result transfer with nothing expected: %p", o_result);
                err_count++;
            end else begin
                want = due_results.pop_front();
                check_field("send_valid",   16'(want.send_valid),
                            16'(o_result.send_valid));
                check_field("packet_seq",   16'(want.packet_seq),
                            16'(o_result.packet_seq));
                check_field("byte_offset",  16'(want.byte_offset),
                            16'(o_result.byte_offset));
                check_field("byte_count",   16'(want.byte_count),
                            16'(o_result.byte_count));
                check_field("final_packet", 16'(want.final_packet),
                            16'(o_result.final_packet));
                check_field("window_base",  16'(want.window_base),
                            16'(o_result.window_base));
                check_field("chunk_done",   16'(want.chunk_done),
                            16'(o_result.chunk_done));
                check_field("last_result",  16'(want.last_result),
                            16'(o_result.last_result));
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_idle) return 0;
        roll = $urandom_range(99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // One command transfer; start stays high when the next item follows at once
    task automatic drive_item(input t_in_item it, input int unsigned gap, input bit typed,
                              input t_out_item want);
        int unsigned held;
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        held = due_results.size();
        window_step(it);
        if (typed) begin
            while (due_results.size() > held) void'(due_results.pop_back());
            due_results.push_back(want);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (due_results.size() != 0 || busy !== 1'b0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_WINDOW_SIZE) win_size_r = data[3:0];
        else                        timeout_r  = data[14:0];
    endtask

    function automatic t_plan_row item_row(t_opcode op, int unsigned seq, int unsigned bytes,
                                           bit fin);
        t_plan_row row;
        row = '{is_cfg: 1'b0, reg_idx: CFG_WINDOW_SIZE, reg_data: '0, item: '0, typed: 1'b0,
                result: '0};
        row.item.opcode      = op;
        row.item.ack_seq     = 3'(seq);
        row.item.chunk_bytes = 14'(bytes);
        row.item.final_chunk = fin;
        return row;
    endfunction

    // Row whose single idle result can be stated outright
    function automatic t_plan_row idle_row(t_opcode op, int unsigned seq, int unsigned bytes,
                                           bit fin, int unsigned want_base, bit want_done);
        t_plan_row row;
        row                    = item_row(op, seq, bytes, fin);
        row.typed              = 1'b1;
        row.result             = '0;
        row.result.window_base = 4'(want_base);
        row.result.chunk_done  = want_done;
        row.result.last_result = 1'b1;
        return row;
    endfunction

    function automatic t_plan_row cfg_row(t_cfg_idx idx, int unsigned data);
        t_plan_row row;
        row = '{is_cfg: 1'b0, reg_idx: CFG_WINDOW_SIZE, reg_data: '0, item: '0, typed: 1'b0,
                result: '0};
        row.is_cfg   = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = CFG_DATA_W'(data);
        return row;
    endfunction

    // Random item, mostly well-formed traffic around the current window
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned roll;
        it.ack_seq     = 3'($urandom);
        it.final_chunk = 1'($urandom);
        roll = $urandom_range(99);
        if (roll < 10)      it.chunk_bytes = 14'($urandom_range(16383, CHUNK_MAX + 1));
        else if (roll < 20) it.chunk_bytes = 14'($urandom_range(PACKETS_PER_CHUNK) * PACKET_BYTES);
        else                it.chunk_bytes = 14'($urandom_range(CHUNK_MAX));
        roll = $urandom_range(99);
        if (base >= total_pkts) begin
            if (roll < 60)      it.opcode = OP_START;
            else if (roll < 75) it.opcode = OP_ACK;
            else if (roll < 85) it.opcode = OP_TICK;
            else                it.opcode = OP_POLL;
        end else begin
            if (roll < 4)       it.opcode = OP_START;
            else if (roll < 44) it.opcode = OP_ACK;
            else if (roll < 70) it.opcode = OP_TICK;
            else                it.opcode = OP_POLL;
        end
        if (it.opcode == OP_ACK && $urandom_range(99) < 85)
            it.ack_seq = 3'(base + $urandom_range(effective_window() - 1));
        return it;
    endfunction

    initial begin
        t_plan_row   plan[$];
        t_out_item   none;
        t_in_item    it;
        t_opcode     wrap_ops [8] = '{OP_START, OP_POLL, OP_TICK, OP_TICK, OP_TICK,
                                      OP_POLL, OP_TICK, OP_POLL};
        int unsigned phase_win [7] = '{8, 1, 3, 15, 0, 6, 5};
        int unsigned phase_tmo [7] = '{2, 0, 5, 1, 4, 32767, 3};

        none       = '0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_WINDOW_SIZE;
        i_cfg_data = '0;

        // model state after reset
        win_size_r = WIN_SIZE_RST;
        timeout_r  = TIMEOUT_RST;
        for (int i = 0; i < SLOTS; i++) begin
            acked[i] = 1'b0;
            sent[i]  = 1'b0;
            stamp[i] = '0;
        end
        base       = 0;
        total_pkts = 0;
        chunk_len  = 0;
        file_end   = 1'b0;
        now_tick   = '0;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: empty window, saturated chunk, holes, timeouts, window extremes
        plan.push_back(idle_row(OP_TICK,  0, 0,     1'b0, 0, 1'b1));
        plan.push_back(idle_row(OP_POLL,  0, 0,     1'b0, 0, 1'b1));
        plan.push_back(idle_row(OP_START, 0, 0,     1'b1, 0, 1'b1));   // empty chunk
        plan.push_back(idle_row(OP_POLL,  0, 0,     1'b0, 0, 1'b1));
        plan.push_back(idle_row(OP_START, 0, 16383, 1'b1, 0, 1'b0));   // saturates
        plan.push_back(item_row(OP_POLL,  0, 0,     1'b0));
        plan.push_back(idle_row(OP_ACK,   7, 0,     1'b0, 0, 1'b0));   // outside window
        plan.push_back(item_row(OP_ACK,   0, 0,     1'b0));
        plan.push_back(item_row(OP_ACK,   2, 0,     1'b0));
        plan.push_back(item_row(OP_POLL,  0, 0,     1'b0));
        repeat (4) plan.push_back(item_row(OP_TICK, 0, 0, 1'b0));
        plan.push_back(item_row(OP_POLL,  0, 0,     1'b0));            // resends
        plan.push_back(cfg_row(CFG_WINDOW_SIZE,   0));                 // acts as one slot
        plan.push_back(cfg_row(CFG_TIMEOUT_TICKS, 0));
        plan.push_back(idle_row(OP_START, 0, 1,     1'b0, 0, 1'b0));
        plan.push_back(item_row(OP_POLL,  0, 0,     1'b0));
        plan.push_back(item_row(OP_TICK,  0, 0,     1'b0));
        plan.push_back(item_row(OP_POLL,  0, 0,     1'b0));
        plan.push_back(cfg_row(CFG_WINDOW_SIZE,   15));                // clamps to full width
        plan.push_back(cfg_row(CFG_TIMEOUT_TICKS, 32767));
        plan.push_back(idle_row(OP_START, 0, 1025,  1'b1, 0, 1'b0));
        plan.push_back(item_row(OP_POLL,  0, 0,     1'b0));
        plan.push_back(idle_row(OP_ACK,   5, 0,     1'b0, 0, 1'b0));   // beyond chunk
        plan.push_back(idle_row(OP_ACK,   1, 0,     1'b0, 0, 1'b0));
        plan.push_back(idle_row(OP_ACK,   0, 0,     1'b0, 0, 1'b0));
        plan.push_back(idle_row(OP_POLL,  0, 0,     1'b0, 2, 1'b1));

        foreach (plan[k]) begin
            if (plan[k].is_cfg) write_reg(plan[k].reg_idx, plan[k].reg_data);
            else drive_item(plan[k].item, pick_gap(), plan[k].typed, plan[k].result);
        end

        // Timeout run: full window sent, aged to the limit, then one tick past it
        write_reg(CFG_WINDOW_SIZE,   SLOTS);
        write_reg(CFG_TIMEOUT_TICKS, 3);
        foreach (wrap_ops[k]) begin
            it             = '0;
            it.opcode      = wrap_ops[k];
            it.chunk_bytes = 14'(CHUNK_MAX);
            it.final_chunk = 1'b1;
            drive_item(it, pick_gap(), 1'b0, none);
        end

        // Random phases over a spread of window and timeout settings
        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_WINDOW_SIZE,   {11'($urandom), 4'(phase_win[p])});
            write_reg(CFG_TIMEOUT_TICKS, 15'(phase_tmo[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 10 == 0) no_idle = ($urandom_range(3) == 0);
                drive_item(random_item(), pick_gap(), 1'b0, none);
            end
        end

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            err_count++;
        end
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
